// ===== rtl/core/duration_uniformity_split_defines.svh =====
// Assertion macros shared by the duration uniformity split RTL.
`ifndef DURATION_UNIFORMITY_SPLIT_DEFINES_SVH
`define DURATION_UNIFORMITY_SPLIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DUS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DUS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/dus_pkg.sv =====
// Package: sizes, payload types, controller states and datapath commands.
`timescale 1ns / 1ps
package dus_pkg;

  localparam int MAX_NOTES = 64;
  localparam int DUR_W     = 24;
  localparam int FRAC_BITS = 16;

  localparam int AW        = $clog2(MAX_NOTES);
  localparam int CW        = $clog2(MAX_NOTES + 1);
  localparam int PVW       = FRAC_BITS + 1;
  localparam int SUMW      = PVW + AW;
  localparam int PAIR_NUMW = DUR_W + FRAC_BITS;
  localparam int NUMW      = (PAIR_NUMW > SUMW) ? PAIR_NUMW : SUMW;
  localparam int DSW       = (DUR_W > CW) ? DUR_W : CW;
  localparam int ITW       = $clog2(NUMW + 1);
  localparam int PV_DEPTH  = 1 << (2 * AW);

  localparam logic [PVW-1:0] Q_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic [23:0] note_length;
    logic        last_note;
  } note_t;

  typedef struct packed {
    logic [16:0] whole_score;
    logic [5:0]  best_split;
    logic [16:0] split_score;
    logic        overflowed;
  } result_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PAIR_RD, ST_PAIR_EVAL, ST_PAIR_DIV, ST_PAIR_WR1, ST_PAIR_WR2,
    ST_END_INIT, ST_SC_START, ST_ROW_START, ST_ROW_RD, ST_ROW_ACC, ST_ROW_DIV,
    ST_ROW_DWAIT, ST_TOT_DIV, ST_TOT_DWAIT, ST_SC_DONE, ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    JOB_WHOLE, JOB_LEFT, JOB_RIGHT
  } job_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_PAIR_RD, OP_PAIR_EVAL, OP_PAIR_DWAIT, OP_PAIR_WR1,
    OP_PAIR_WR2, OP_END_INIT, OP_SC_START, OP_ROW_START, OP_ROW_RD, OP_ROW_ACC,
    OP_ROW_DIV, OP_ROW_DWAIT, OP_TOT_DIV, OP_TOT_DWAIT, OP_KEEP_WHOLE,
    OP_KEEP_LEFT, OP_KEEP_RIGHT, OP_FINISH
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pair_trivial;
    logic pair_last;
    logic div_done;
    logic short_part;
    logic row_last;
    logic part_last;
    logic few_notes;
    logic split_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/duration_uniformity_split.sv =====
// Top level of the duration uniformity scorer with best split search.
`timescale 1ns / 1ps
// Notes arrive one transaction at a time on the note channel and are held in a
// 64-entry duration store; further notes in the same run are dropped and the
// overflow flag is raised. As each note is stored, its pair value against every
// earlier note of the run is worked out on a shared bit-serial divider (40
// quotient steps) and written to a pair-value RAM; a pair that needs no
// division skips the divider. The note marked last starts scoring: the whole
// run, then both parts at every split position, each part summed row by row
// from the pair-value RAM with one divider pass per row and one per part. One
// result transaction is then offered; the note channel is ready again as soon as
// the result sits in the output register. Scores are unsigned Q1.16.
module duration_uniformity_split import dus_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    note_valid,
  output logic    note_ready,
  input  note_t   note,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  op_t        op;
  dp_status_t stat;

  // Sequence loading, pair evaluation and the split search.
  dus_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .note_valid (note_valid),
    .last_note  (note.last_note),
    .note_ready (note_ready),
    .stat       (stat),
    .op         (op)
  );

  // Hold the stores, counters and the divider; drive the result register.
  dus_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .note         (note),
    .stat         (stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== rtl/core/dus_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module dus_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/dus_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module dus_div import dus_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DSW-1:0]  den,
  output logic            busy,
  output logic            done,
  output logic [NUMW-1:0] quo
);

  logic [DSW-1:0] rem;
  logic [DSW-1:0] dsr;
  logic [ITW-1:0] iter;
  logic [DSW:0]   trial;
  logic           take;

  assign trial = {rem, quo[NUMW-1]};
  assign take  = (trial >= {1'b0, dsr});
  assign done  = busy && (iter == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= ITW'(NUMW);
    end else if (busy) begin
      if (iter == '0) begin
        busy <= 1'b0;
      end else begin
        iter <= iter - ITW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dsr <= den;
    end else if (busy && iter != '0) begin
      rem <= take ? DSW'(trial - {1'b0, dsr}) : DSW'(trial);
      quo <= {quo[NUMW-2:0], take};
    end
  end

endmodule

// ===== rtl/core/dus_ctrl.sv =====
// Controller state machine: sequences note loading and run scoring.
`timescale 1ns / 1ps
module dus_ctrl import dus_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       note_valid,
  input  logic       last_note,
  output logic       note_ready,
  input  dp_status_t stat,
  output op_t        op
);

  state_t state, state_next;
  job_t   job, job_next;
  logic   run_last, run_last_next;
  logic   accept;

  assign accept = note_valid && note_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      job      <= JOB_WHOLE;
      run_last <= 1'b0;
    end else begin
      state    <= state_next;
      job      <= job_next;
      run_last <= run_last_next;
    end
  end

  always_comb begin
    state_next    = state;
    job_next      = job;
    run_last_next = run_last;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          run_last_next = last_note;
          if (!stat.full && !stat.empty) begin
            state_next = ST_PAIR_RD;
          end else if (last_note) begin
            state_next = ST_END_INIT;
          end
        end
      end
      ST_PAIR_RD:   state_next = ST_PAIR_EVAL;
      ST_PAIR_EVAL: state_next = stat.pair_trivial ? ST_PAIR_WR1 : ST_PAIR_DIV;
      ST_PAIR_DIV: begin
        if (stat.div_done) begin
          state_next = ST_PAIR_WR1;
        end
      end
      ST_PAIR_WR1:  state_next = ST_PAIR_WR2;
      ST_PAIR_WR2: begin
        if (!stat.pair_last) begin
          state_next = ST_PAIR_RD;
        end else begin
          state_next = run_last ? ST_END_INIT : ST_IDLE;
        end
      end
      ST_END_INIT: begin
        job_next   = JOB_WHOLE;
        state_next = ST_SC_START;
      end
      ST_SC_START:  state_next = stat.short_part ? ST_SC_DONE : ST_ROW_START;
      ST_ROW_START: state_next = ST_ROW_RD;
      ST_ROW_RD:    state_next = ST_ROW_ACC;
      ST_ROW_ACC:   state_next = stat.row_last ? ST_ROW_DIV : ST_ROW_RD;
      ST_ROW_DIV:   state_next = ST_ROW_DWAIT;
      ST_ROW_DWAIT: begin
        if (stat.div_done) begin
          state_next = stat.part_last ? ST_TOT_DIV : ST_ROW_START;
        end
      end
      ST_TOT_DIV:   state_next = ST_TOT_DWAIT;
      ST_TOT_DWAIT: begin
        if (stat.div_done) begin
          state_next = ST_SC_DONE;
        end
      end
      ST_SC_DONE: begin
        case (job)
          JOB_WHOLE: begin
            job_next   = JOB_LEFT;
            state_next = stat.few_notes ? ST_FINISH : ST_SC_START;
          end
          JOB_LEFT: begin
            job_next   = JOB_RIGHT;
            state_next = ST_SC_START;
          end
          default: begin
            job_next   = JOB_LEFT;
            state_next = stat.split_last ? ST_FINISH : ST_SC_START;
          end
        endcase
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    note_ready = (state == ST_IDLE);
    op         = OP_NONE;
    case (state)
      ST_IDLE:      op = accept ? OP_LOAD : OP_NONE;
      ST_PAIR_RD:   op = OP_PAIR_RD;
      ST_PAIR_EVAL: op = OP_PAIR_EVAL;
      ST_PAIR_DIV:  op = OP_PAIR_DWAIT;
      ST_PAIR_WR1:  op = OP_PAIR_WR1;
      ST_PAIR_WR2:  op = OP_PAIR_WR2;
      ST_END_INIT:  op = OP_END_INIT;
      ST_SC_START:  op = OP_SC_START;
      ST_ROW_START: op = OP_ROW_START;
      ST_ROW_RD:    op = OP_ROW_RD;
      ST_ROW_ACC:   op = OP_ROW_ACC;
      ST_ROW_DIV:   op = OP_ROW_DIV;
      ST_ROW_DWAIT: op = OP_ROW_DWAIT;
      ST_TOT_DIV:   op = OP_TOT_DIV;
      ST_TOT_DWAIT: op = OP_TOT_DWAIT;
      ST_SC_DONE: begin
        case (job)
          JOB_WHOLE: op = OP_KEEP_WHOLE;
          JOB_LEFT:  op = OP_KEEP_LEFT;
          default:   op = OP_KEEP_RIGHT;
        endcase
      end
      ST_FINISH:    op = stat.out_free ? OP_FINISH : OP_NONE;
      default:      op = OP_NONE;
    endcase
  end

endmodule

// ===== rtl/core/dus_datapath.sv =====
// Datapath: note and pair-value stores, loop counters, divider, result register.
`timescale 1ns / 1ps
`include "duration_uniformity_split_defines.svh"
module dus_datapath import dus_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  op_t        op,
  input  note_t      note,
  output dp_status_t stat,
  output logic       result_valid,
  input  logic       result_ready,
  output result_t    result
);

  logic [CW-1:0]    cnt;
  logic             ovf;
  logic [DUR_W-1:0] cur;
  logic [CW-1:0]    idx, jdx, first, plen, pos;
  logic [SUMW-1:0]  row, total;
  logic [PVW-1:0]   pv, score, sc_whole, sc_left, best;
  logic [AW-1:0]    best_pos;

  logic [DUR_W-1:0] dur_rd, big, lesser;
  logic [PVW-1:0]   pv_rd;
  logic [AW-1:0]    k;
  logic             dur_we, pv_we;
  logic [2*AW-1:0]  pv_waddr;
  logic [PVW:0]     pair_sum;
  logic [PVW-1:0]   cand;

  logic             div_start, div_busy, div_done;
  logic [NUMW-1:0]  div_num, div_q;
  logic [DSW-1:0]   div_den;

  assign big    = (cur > dur_rd) ? cur : dur_rd;
  assign lesser = (cur > dur_rd) ? dur_rd : cur;
  assign k      = AW'(cnt - CW'(1));

  assign dur_we   = (op == OP_LOAD) && (cnt != CW'(MAX_NOTES));
  assign pv_we    = (op == OP_PAIR_WR1) || (op == OP_PAIR_WR2);
  assign pv_waddr = (op == OP_PAIR_WR1) ? {k, jdx[AW-1:0]} : {jdx[AW-1:0], k};

  dus_ram #(.WIDTH(DUR_W), .DEPTH(MAX_NOTES)) u_dur_ram (
    .clk   (clk),
    .we    (dur_we),
    .waddr (cnt[AW-1:0]),
    .wdata (DUR_W'(note.note_length)),
    .raddr (jdx[AW-1:0]),
    .rdata (dur_rd)
  );

  dus_ram #(.WIDTH(PVW), .DEPTH(PV_DEPTH)) u_pv_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv),
    .raddr ({idx[AW-1:0], jdx[AW-1:0]}),
    .rdata (pv_rd)
  );

  always_comb begin
    div_start = 1'b0;
    div_num   = NUMW'(row);
    div_den   = DSW'(plen - CW'(1));
    case (op)
      OP_PAIR_EVAL: begin
        div_start = !stat.pair_trivial;
        div_num   = NUMW'({(big - lesser), {FRAC_BITS{1'b0}}});
        div_den   = DSW'(lesser);
      end
      OP_ROW_DIV: div_start = 1'b1;
      OP_TOT_DIV: begin
        div_start = 1'b1;
        div_num   = NUMW'(total);
        div_den   = DSW'(plen);
      end
      default: div_start = 1'b0;
    endcase
  end

  dus_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  assign pair_sum = {1'b0, sc_left} + {1'b0, score};
  assign cand     = pair_sum[PVW:1];

  always_comb begin
    stat.full         = (cnt == CW'(MAX_NOTES));
    stat.empty        = (cnt == '0);
    stat.pair_trivial = (lesser == '0) || ({1'b0, big} >= {lesser, 1'b0});
    stat.pair_last    = (CW'(jdx + CW'(2)) == cnt);
    stat.div_done     = div_done;
    stat.short_part   = (plen < CW'(2));
    stat.row_last     = (CW'(jdx + CW'(1)) == CW'(first + plen));
    stat.part_last    = (CW'(idx + CW'(1)) == CW'(first + plen));
    stat.few_notes    = (cnt < CW'(2));
    stat.split_last   = (CW'(pos + CW'(1)) == cnt);
    stat.out_free     = !result_valid || result_ready;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (op == OP_LOAD) begin
        if (stat.full) begin
          ovf <= 1'b1;
        end else begin
          cnt <= cnt + CW'(1);
        end
      end
      if (op == OP_FINISH) begin
        cnt          <= '0;
        ovf          <= 1'b0;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        cur <= DUR_W'(note.note_length);
        jdx <= '0;
      end
      OP_PAIR_EVAL: begin
        pv <= (big == '0) ? Q_ONE : '0;
      end
      OP_PAIR_DWAIT: begin
        if (div_done) begin
          pv <= Q_ONE - PVW'(div_q[FRAC_BITS-1:0]);
        end
      end
      OP_PAIR_WR2: jdx <= jdx + CW'(1);
      OP_END_INIT: begin
        pos      <= CW'(1);
        best     <= '0;
        best_pos <= '0;
        first    <= '0;
        plen     <= cnt;
      end
      OP_SC_START: begin
        score <= Q_ONE;
        idx   <= first;
        total <= '0;
      end
      OP_ROW_START: begin
        row <= '0;
        jdx <= first;
      end
      OP_ROW_ACC: begin
        if (jdx != idx) begin
          row <= row + SUMW'(pv_rd);
        end
        jdx <= jdx + CW'(1);
      end
      OP_ROW_DWAIT: begin
        if (div_done) begin
          total <= total + SUMW'(div_q);
          idx   <= idx + CW'(1);
        end
      end
      OP_TOT_DWAIT: begin
        if (div_done) begin
          score <= PVW'(div_q);
        end
      end
      OP_KEEP_WHOLE: begin
        sc_whole <= score;
        first    <= '0;
        plen     <= pos;
      end
      OP_KEEP_LEFT: begin
        sc_left <= score;
        first   <= pos;
        plen    <= cnt - pos;
      end
      OP_KEEP_RIGHT: begin
        if (cand > best) begin
          best     <= cand;
          best_pos <= pos[AW-1:0];
        end
        pos   <= pos + CW'(1);
        first <= '0;
        plen  <= pos + CW'(1);
      end
      OP_FINISH: begin
        result.whole_score <= 17'(sc_whole);
        result.best_split  <= 6'(best_pos);
        result.split_score <= 17'(best);
        result.overflowed  <= ovf;
      end
      default: begin
      end
    endcase
  end

  `DUS_ASSERT_NOW(a_cnt_range, 1'b1, cnt <= CW'(MAX_NOTES), "note count beyond store depth")
  `DUS_ASSERT_NOW(a_div_idle, div_start, !div_busy, "divider started while busy")
  `DUS_ASSERT_NEXT(a_finish, op == OP_FINISH, result_valid && cnt == '0 && !ovf, "finish did not post result")

endmodule
